@@ rtl/assert_macros.svh @@
// Assertion helpers; the including scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/fmps_pkg.sv @@
`timescale 1ns / 1ps
package fmps_pkg;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int NUM_W       = 11;

    localparam logic [1:0] FUNC_ARRIVE = 2'd0;
    localparam logic [1:0] FUNC_OLDEST = 2'd1;
    localparam logic [1:0] FUNC_BEST   = 2'd2;

    localparam logic [1:0] ST_SERVED = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]             func;
        logic [VALUE_WIDTH-1:0] priority_value;
    } item_t;

    typedef struct packed {
        logic [NUM_W-1:0] customer_number;
        logic [1:0]       status;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARRIVE,
        S_NONE,
        S_OLD_RD,
        S_OLD_CK,
        S_OLD_HIT,
        S_BEST_INIT,
        S_BEST_LOOP,
        S_BEST_DONE
    } step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ARRIVE,
        OP_EMPTY,
        OP_OLD_READ,
        OP_OLD_SKIP,
        OP_OLD_SERVE,
        OP_BEST_INIT,
        OP_BEST_SCAN,
        OP_BEST_SERVE
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_OLD_EMPTY,
        C_MARKED,
        C_SCAN
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    // Control store: one word per step.
    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            S_IDLE:      w = '{op: OP_NOP,        cond: C_DISPATCH,  target: S_IDLE};
            S_ARRIVE:    w = '{op: OP_ARRIVE,     cond: C_ALWAYS,    target: S_IDLE};
            S_NONE:      w = '{op: OP_EMPTY,      cond: C_ALWAYS,    target: S_IDLE};
            S_OLD_RD:    w = '{op: OP_OLD_READ,   cond: C_OLD_EMPTY, target: S_NONE};
            S_OLD_CK:    w = '{op: OP_OLD_SKIP,   cond: C_MARKED,    target: S_OLD_RD};
            S_OLD_HIT:   w = '{op: OP_OLD_SERVE,  cond: C_ALWAYS,    target: S_IDLE};
            S_BEST_INIT: w = '{op: OP_BEST_INIT,  cond: C_NEXT,      target: S_IDLE};
            S_BEST_LOOP: w = '{op: OP_BEST_SCAN,  cond: C_SCAN,      target: S_BEST_LOOP};
            S_BEST_DONE: w = '{op: OP_BEST_SERVE, cond: C_ALWAYS,    target: S_IDLE};
            default:     w = '{op: OP_NOP,        cond: C_ALWAYS,    target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/fifo_and_max_priority_server.sv @@
// Busy covers the steps below; done strobes in the next cycle, when a new start is taken.
// Arrival writes the stores and reports queued or full; unused codes report empty.
// Serve oldest skips served entries at the head and serves the next; empty if none waits.
// Serve best scans unserved entries from the oldest pointer for the largest value.
// Reset clears the sequencer, counters and strobe; the stores keep their contents and the
// served mark of an entry is rewritten when it arrives, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fifo_and_max_priority_server
    import fmps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
    logic                   srv_mem [CAPACITY];

    step_t                  upc_reg, upc_next;
    uword_t                 uw;
    item_t                  item_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       optr_reg, optr_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       pidx_reg, pidx_next;
    logic                   pipe_reg, pipe_next;
    logic                   found_reg, found_next;
    logic [CNT_W-1:0]       best_idx_reg, best_idx_next;
    logic [VALUE_WIDTH-1:0] best_val_reg, best_val_next;
    logic                   done_reg, done_next;
    result_t                res_reg, res_next;

    logic [VALUE_WIDTH-1:0] val_q_reg;
    logic                   srv_q_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   val_we, srv_we, srv_wdata;
    logic                   scan_more;
    logic                   jump;

    assign uw        = ucode(upc_reg);
    assign busy      = (upc_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign scan_more = (idx_reg < count_reg);
    assign rd_addr   = (uw.op == OP_BEST_SCAN) ? idx_reg[ADDR_W-1:0] : optr_reg[ADDR_W-1:0];

    // Store ports: one write, one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[wr_addr] <= item_reg.priority_value;
        end
        val_q_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (srv_we)
        begin
            srv_mem[wr_addr] <= srv_wdata;
        end
        srv_q_reg <= srv_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
        pidx_reg     <= pidx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        res_reg      <= res_next;
        idx_reg      <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg   <= S_IDLE;
            count_reg <= '0;
            optr_reg  <= '0;
            pipe_reg  <= 1'b0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            upc_reg   <= upc_next;
            count_reg <= count_next;
            optr_reg  <= optr_next;
            pipe_reg  <= pipe_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    // Sequencer: branch condition and next step.
    always_comb
    begin
        jump     = 1'b0;
        upc_next = upc_reg;
        unique case (uw.cond)
            C_NEXT:      jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_DISPATCH:  jump = 1'b1;
            C_OLD_EMPTY: jump = (optr_reg >= count_reg);
            C_MARKED:    jump = srv_q_reg;
            C_SCAN:      jump = scan_more || pipe_reg;
            default:     jump = 1'b1;
        endcase

        if (uw.cond == C_DISPATCH)
        begin
            if (start)
            begin
                unique case (item.func)
                    FUNC_ARRIVE: upc_next = S_ARRIVE;
                    FUNC_OLDEST: upc_next = S_OLD_RD;
                    FUNC_BEST:   upc_next = S_BEST_INIT;
                    default:     upc_next = S_NONE;
                endcase
            end
        end
        else if (jump)
        begin
            upc_next = uw.target;
        end
        else
        begin
            upc_next = step_t'(upc_reg + 4'd1);
        end
    end

    // Datapath driven by the control word.
    always_comb
    begin
        count_next    = count_reg;
        optr_next     = optr_reg;
        idx_next      = idx_reg;
        pidx_next     = pidx_reg;
        pipe_next     = 1'b0;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        val_we        = 1'b0;
        srv_we        = 1'b0;
        srv_wdata     = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];

        unique case (uw.op)
            OP_NOP:
            begin
                done_next = 1'b0;
            end
            OP_ARRIVE:
            begin
                done_next = 1'b1;
                if (count_reg == CNT_W'(CAPACITY))
                begin
                    res_next = '{customer_number: '0, status: ST_FULL};
                end
                else
                begin
                    val_we     = 1'b1;
                    srv_we     = 1'b1;
                    srv_wdata  = 1'b0;
                    count_next = count_reg + 1'b1;
                    res_next   = '{customer_number: NUM_W'(count_reg + 1'b1),
                                   status: ST_QUEUED};
                end
            end
            OP_EMPTY:
            begin
                done_next = 1'b1;
                res_next  = '{customer_number: '0, status: ST_EMPTY};
            end
            OP_OLD_READ:
            begin
                done_next = 1'b0;
            end
            OP_OLD_SKIP:
            begin
                // advance past an entry already taken by a best-value serve
                if (srv_q_reg)
                begin
                    optr_next = optr_reg + 1'b1;
                end
            end
            OP_OLD_SERVE:
            begin
                srv_we    = 1'b1;
                srv_wdata = 1'b1;
                wr_addr   = optr_reg[ADDR_W-1:0];
                optr_next = optr_reg + 1'b1;
                done_next = 1'b1;
                res_next  = '{customer_number: NUM_W'(optr_reg + 1'b1), status: ST_SERVED};
            end
            OP_BEST_INIT:
            begin
                idx_next   = optr_reg;
                found_next = 1'b0;
            end
            OP_BEST_SCAN:
            begin
                // issue the read for idx while judging the entry read last cycle
                if (scan_more)
                begin
                    pipe_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + 1'b1;
                end
                if (pipe_reg && !srv_q_reg && (!found_reg || val_q_reg > best_val_reg))
                begin
                    found_next    = 1'b1;
                    best_idx_next = pidx_reg;
                    best_val_next = val_q_reg;
                end
            end
            OP_BEST_SERVE:
            begin
                done_next = 1'b1;
                if (found_reg)
                begin
                    srv_we    = 1'b1;
                    srv_wdata = 1'b1;
                    wr_addr   = best_idx_reg[ADDR_W-1:0];
                    res_next  = '{customer_number: NUM_W'(best_idx_reg + 1'b1),
                                  status: ST_SERVED};
                end
                else
                begin
                    res_next = '{customer_number: '0, status: ST_EMPTY};
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    `ASSERT_IMPL(a_done_when_idle, done, !busy)
    `ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
    `ASSERT_IMPL(a_oldest_within_count, 1'b1, optr_reg <= count_reg)
    `ASSERT_IMPL(a_queued_number, done && (result.status == ST_QUEUED),
                 result.customer_number == NUM_W'(count_reg))

endmodule
